FILE: hw/rtl/ptl_pkg.sv
// Shared types and constants of the predictive token lexer.
// Depends on nothing; used by the core, the top level and the testbench.
`default_nettype none
package ptl_pkg;

   typedef enum logic [1:0] {
      OP_PROBE    = 2'd0,
      OP_BEGIN    = 2'd1,
      OP_CONTINUE = 2'd2,
      OP_NONE     = 2'd3
   } opcode_type;

   typedef enum logic [3:0] {
      ERR_NONE        = 4'd0,
      ERR_BAD_CHAR    = 4'd1,
      ERR_EARLY_END   = 4'd2,
      ERR_NL_QUOTE    = 4'd3,
      ERR_EMPTY_BR    = 4'd4,
      ERR_BAD_OPTION  = 4'd5,
      ERR_NO_BRACE    = 4'd6,
      ERR_EMPTY_TOKEN = 4'd7,
      ERR_NO_PROBE    = 4'd8
   } error_type;

   typedef enum logic [4:0] {
      P_IDLE, P_START, P_ARROW2, P_WS_MORE, P_CM_SLASH, P_CM_LINE, P_CM_BLOCK,
      P_CM_STAR, P_BR_FIRST, P_BR_MORE, P_QUOTE, P_U_MORE, P_E_DOLLAR, P_E_FIRST,
      P_E_REST, P_N_REST, P_G_REST, P_A_USER, P_I_DIG, P_I_FIRST, P_WORD_T,
      P_WORD_F, P_O1, P_O2, P_FL_INT, P_FL_FRAC, P_FL_EXP0, P_FL_EXPD
   } phase_type;

   localparam logic [4:0] K_EOF      = 5'd0;
   localparam logic [4:0] K_ARROW    = 5'd9;
   localparam logic [4:0] K_WS       = 5'd10;
   localparam logic [4:0] K_COMMENT  = 5'd11;
   localparam logic [4:0] K_PERM     = 5'd12;
   localparam logic [4:0] K_SRV_OPT  = 5'd13;
   localparam logic [4:0] K_CLI_OPT  = 5'd14;
   localparam logic [4:0] K_ARG      = 5'd15;
   localparam logic [4:0] K_PATH     = 5'd16;
   localparam logic [4:0] K_FNAME    = 5'd17;
   localparam logic [4:0] K_NAME     = 5'd18;
   localparam logic [4:0] K_GROUP    = 5'd19;
   localparam logic [4:0] K_AGENT    = 5'd20;
   localparam logic [4:0] K_INT      = 5'd21;
   localparam logic [4:0] K_SINT     = 5'd22;
   localparam logic [4:0] K_BOOL     = 5'd23;
   localparam logic [4:0] K_FLOAT    = 5'd24;
   localparam logic [4:0] K_STRING   = 5'd25;

   localparam logic [8:0] END_CH = 9'h100;

   typedef struct packed {
      logic [4:0] kind;
      phase_type  phase;
      logic       quote_dbl;
      logic       brace_open;
      logic [2:0] cand;
      logic [3:0] pos;
   } lex_state_type;

   typedef struct packed {
      logic      consumed;
      logic      token_done;
      logic      could_match;
      error_type error_code;
   } lex_flags_type;

endpackage
`default_nettype wire

FILE: hw/rtl/ptl_if.sv
// Request and response channel interfaces of the token lexer.
// Depends on ptl_pkg for nothing but shares its widths with the top level.
`default_nettype none
interface ptl_req_if (input wire logic clock);
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [4:0] token_kind;
   logic [7:0] current_char;
   logic       current_is_end;
   logic [7:0] lookahead_char;
   logic       lookahead_is_end;
   modport source (output valid, opcode, token_kind, current_char, current_is_end,
                   lookahead_char, lookahead_is_end, input ready);
   modport sink (input valid, opcode, token_kind, current_char, current_is_end,
                 lookahead_char, lookahead_is_end, output ready);
endinterface

interface ptl_rsp_if #(parameter int LINE_BITS = 20, parameter int COLUMN_BITS = 16)
   (input wire logic clock);
   logic                   valid;
   logic                   ready;
   logic                   consumed;
   logic                   token_done;
   logic                   could_match;
   logic [3:0]             error_code;
   logic [LINE_BITS-1:0]   line_number;
   logic [COLUMN_BITS-1:0] column_number;
   modport source (output valid, consumed, token_done, could_match, error_code,
                   line_number, column_number, input ready);
   modport sink (input valid, consumed, token_done, could_match, error_code,
                 line_number, column_number, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/ptl_core.sv
// Combinational lexer step: next token state and flags for one byte.
// Depends on ptl_pkg.
`default_nettype none
module ptl_core
   import ptl_pkg::*;
(
   input  wire logic [1:0]    opcode,
   input  wire logic [4:0]    token_kind,
   input  wire logic [8:0]    cur,
   input  wire logic [8:0]    la,
   input  lex_state_type      state_cur,
   output lex_state_type      state_nxt,
   output lex_flags_type      flags
);

   typedef struct packed {
      lex_state_type st;
      logic          cons;
      logic          done;
      error_type     err;
      logic          again;
   } step_type;

   localparam logic [95:0] W_MANUAL = "manual-start";
   localparam logic [39:0] W_ASYNC  = "async";
   localparam logic [79:0] W_TYPES  = "types-only";
   localparam logic [31:0] W_TRUE   = "true";
   localparam logic [39:0] W_FALSE  = "false";

   function automatic logic eq(logic [8:0] c, logic [7:0] b);
      return c == {1'b0, b};
   endfunction
   function automatic logic in_rng(logic [8:0] c, logic [7:0] lo, logic [7:0] hi);
      return !c[8] && c[7:0] >= lo && c[7:0] <= hi;
   endfunction
   function automatic logic is_lower(logic [8:0] c);
      return in_rng(c, "a", "z");
   endfunction
   function automatic logic is_digit(logic [8:0] c);
      return in_rng(c, "0", "9");
   endfunction
   function automatic logic id_start(logic [8:0] c);
      return is_lower(c) || in_rng(c, "A", "Z") || eq(c, "_");
   endfunction
   function automatic logic id_char(logic [8:0] c);
      return id_start(c) || is_digit(c);
   endfunction
   function automatic logic is_ws(logic [8:0] c);
      return eq(c, " ") || eq(c, 8'h09) || eq(c, 8'h0A) || eq(c, 8'h0D);
   endfunction
   function automatic logic name_char(logic [8:0] c);
      return id_char(c) || eq(c, ".") || eq(c, "$") || eq(c, "-") || eq(c, ":") ||
             eq(c, ";") || eq(c, "+") || eq(c, "=") || eq(c, "?");
   endfunction
   function automatic logic [8:0] single_ch(logic [4:0] k);
      logic [8:0] r;
      case (k)
         5'd1: r = {1'b0, "{"};
         5'd2: r = {1'b0, "}"};
         5'd3: r = {1'b0, "("};
         5'd4: r = {1'b0, ")"};
         5'd5: r = {1'b0, ":"};
         5'd6: r = {1'b0, "="};
         5'd7: r = {1'b0, "."};
         5'd8: r = {1'b0, "*"};
         default: r = END_CH;
      endcase
      return r;
   endfunction
   function automatic logic opt_hit(int i, logic [3:0] pos, logic [8:0] c);
      logic hit;
      int p;
      hit = 1'b0;
      p = int'(pos);
      case (i)
         0: if (p < 12) hit = eq(c, W_MANUAL[8*(11-p) +: 8]);
         1: if (p < 5) hit = eq(c, W_ASYNC[8*(4-p) +: 8]);
         default: if (p < 10) hit = eq(c, W_TYPES[8*(9-p) +: 8]);
      endcase
      return hit;
   endfunction
   function automatic logic word_hit(logic is_false, logic [3:0] pos, logic [8:0] c);
      logic hit;
      int p;
      hit = 1'b0;
      p = int'(pos);
      if (is_false) begin
         if (p < 5) hit = eq(c, W_FALSE[8*(4-p) +: 8]);
      end else begin
         if (p < 4) hit = eq(c, W_TRUE[8*(3-p) +: 8]);
      end
      return hit;
   endfunction

   function automatic step_type fail(step_type r, error_type e);
      step_type o;
      o = r;
      o.err = e;
      o.st.phase = P_IDLE;
      return o;
   endfunction
   function automatic step_type finish(step_type r);
      step_type o;
      o = r;
      o.done = 1'b1;
      o.st.phase = P_IDLE;
      return o;
   endfunction
   function automatic step_type take_to(step_type r, phase_type p);
      step_type o;
      o = r;
      o.cons = 1'b1;
      o.st.phase = p;
      return o;
   endfunction

   function automatic step_type unquoted(step_type r, logic [8:0] c, logic [8:0] l,
                                         logic first);
      logic pathy, cls, cmt;
      pathy = r.st.kind != K_FNAME;
      cls = name_char(c) || (pathy && eq(c, "/"));
      cmt = pathy && eq(c, "/") && (eq(l, "/") || eq(l, "*"));
      if (eq(c, "$")) return take_to(r, P_E_DOLLAR);
      if (cls && !cmt) return take_to(r, P_U_MORE);
      if (first) return fail(r, ERR_BAD_CHAR);
      return finish(r);
   endfunction

   function automatic step_type bracket_inner(step_type r, logic [8:0] c);
      step_type o;
      logic opt;
      o = r;
      opt = r.st.kind != K_PERM;
      if (c == END_CH) return fail(r, ERR_EARLY_END);
      if (opt ? !(eq(c, "-") || is_lower(c)) : !(eq(c, "r") || eq(c, "w") || eq(c, "x")))
         return fail(r, ERR_BAD_CHAR);
      o = take_to(o, P_BR_MORE);
      if (opt) begin
         for (int i = 0; i < 3; i++)
            if (!opt_hit(i, r.st.pos, c)) o.st.cand[i] = 1'b0;
         if (r.st.pos != 4'd15) o.st.pos = r.st.pos + 4'd1;
      end
      return o;
   endfunction

   function automatic logic option_ok(lex_state_type s);
      logic [2:0] m;
      m = ((s.kind == K_SRV_OPT) ? 3'b011 : 3'b101) & s.cand;
      return (m[0] && s.pos == 4'd12) || (m[1] && s.pos == 4'd5) ||
             (m[2] && s.pos == 4'd10);
   endfunction

   function automatic step_type lex_start(step_type r, logic [8:0] c, logic [8:0] l);
      step_type o;
      logic [4:0] k;
      o = r;
      k = r.st.kind;
      if (k >= 5'd1 && k <= 5'd8) begin
         if (c == single_ch(k)) return finish(take_to(o, P_IDLE));
         return fail(o, ERR_BAD_CHAR);
      end
      case (k)
         K_EOF: o = (c == END_CH) ? finish(o) : fail(o, ERR_BAD_CHAR);
         K_ARROW: o = eq(c, "-") ? take_to(o, P_ARROW2) : fail(o, ERR_BAD_CHAR);
         K_WS: o = is_ws(c) ? take_to(o, P_WS_MORE) : fail(o, ERR_EMPTY_TOKEN);
         K_COMMENT: o = eq(c, "/") ? take_to(o, P_CM_SLASH) : fail(o, ERR_BAD_CHAR);
         K_PERM, K_SRV_OPT, K_CLI_OPT:
            o = eq(c, "[") ? take_to(o, P_BR_FIRST) : fail(o, ERR_BAD_CHAR);
         K_ARG, K_PATH, K_FNAME, K_STRING: begin
            if (eq(c, "\"") || eq(c, "'")) begin
               o.st.quote_dbl = eq(c, "\"");
               o = take_to(o, P_QUOTE);
            end else if (k == K_STRING) begin
               o = fail(o, ERR_BAD_CHAR);
            end else begin
               o = unquoted(o, c, l, 1'b1);
            end
         end
         K_NAME, K_GROUP:
            o = id_start(c) ? take_to(o, (k == K_NAME) ? P_N_REST : P_G_REST)
                            : fail(o, ERR_BAD_CHAR);
         K_AGENT:
            o = eq(c, "<") ? take_to(o, P_A_USER)
              : id_start(c) ? take_to(o, P_N_REST) : fail(o, ERR_BAD_CHAR);
         K_INT: begin
            o.st.phase = P_I_FIRST;
            o.again = 1'b1;
         end
         K_SINT: begin
            if (eq(c, "+") || eq(c, "-")) begin
               o = take_to(o, P_I_FIRST);
            end else begin
               o.st.phase = P_I_FIRST;
               o.again = 1'b1;
            end
         end
         K_BOOL: begin
            if (eq(c, "t") || eq(c, "f")) begin
               o.st.pos = 4'd1;
               o = take_to(o, eq(c, "t") ? P_WORD_T : P_WORD_F);
            end else if (eq(c, "o")) begin
               o = take_to(o, P_O1);
            end else begin
               o = fail(o, ERR_BAD_CHAR);
            end
         end
         K_FLOAT:
            o = (is_digit(c) || eq(c, "+") || eq(c, "-")) ? take_to(o, P_FL_INT)
                                                          : fail(o, ERR_BAD_CHAR);
         default: o = finish(o);
      endcase
      return o;
   endfunction

   function automatic step_type lex_step(lex_state_type s, logic [8:0] c, logic [8:0] l);
      step_type r;
      phase_type p;
      r.st = s;
      r.cons = 1'b0;
      r.done = 1'b0;
      r.err = ERR_NONE;
      r.again = 1'b0;
      p = s.phase;
      case (p)
         P_START: r = lex_start(r, c, l);
         P_ARROW2: r = eq(c, ">") ? finish(take_to(r, P_IDLE)) : fail(r, ERR_BAD_CHAR);
         P_WS_MORE: r = is_ws(c) ? take_to(r, p) : finish(r);
         P_CM_SLASH:
            r = eq(c, "/") ? take_to(r, P_CM_LINE)
              : eq(c, "*") ? take_to(r, P_CM_BLOCK) : fail(r, ERR_BAD_CHAR);
         P_CM_LINE: r = (eq(c, 8'h0A) || c == END_CH) ? finish(r) : take_to(r, p);
         P_CM_BLOCK, P_CM_STAR: begin
            if (p == P_CM_STAR && eq(c, "/")) r = finish(take_to(r, P_IDLE));
            else if (eq(c, "*")) r = take_to(r, P_CM_STAR);
            else if (c == END_CH) r = fail(r, ERR_EARLY_END);
            else r = take_to(r, P_CM_BLOCK);
         end
         P_BR_FIRST: r = eq(c, "]") ? fail(r, ERR_EMPTY_BR) : bracket_inner(r, c);
         P_BR_MORE: begin
            if (eq(c, "]")) begin
               r = take_to(r, P_IDLE);
               r = (s.kind != K_PERM && !option_ok(s)) ? fail(r, ERR_BAD_OPTION)
                                                         : finish(r);
            end else begin
               r = bracket_inner(r, c);
            end
         end
         P_QUOTE: begin
            if (c == {1'b0, (s.quote_dbl ? 8'h22 : 8'h27)}) r = finish(take_to(r, P_IDLE));
            else if (c == END_CH) r = fail(r, ERR_EARLY_END);
            else if (eq(c, 8'h0A) || eq(c, 8'h0D)) r = fail(r, ERR_NL_QUOTE);
            else r = take_to(r, p);
         end
         P_U_MORE: r = unquoted(r, c, l, 1'b0);
         P_E_DOLLAR: begin
            if (eq(c, "{")) begin
               r.st.brace_open = 1'b1;
               r = take_to(r, P_E_FIRST);
            end else begin
               r.st.brace_open = 1'b0;
               r.st.phase = P_E_FIRST;
               r.again = 1'b1;
            end
         end
         P_E_FIRST: r = id_start(c) ? take_to(r, P_E_REST) : fail(r, ERR_BAD_CHAR);
         P_E_REST: begin
            if (id_char(c)) begin
               r = take_to(r, p);
            end else if (!s.brace_open) begin
               r.st.phase = P_U_MORE;
               r.again = 1'b1;
            end else if (eq(c, "}")) begin
               r.st.brace_open = 1'b0;
               r = take_to(r, P_U_MORE);
            end else if (c == END_CH) begin
               r = fail(r, ERR_EARLY_END);
            end else begin
               r = fail(r, ERR_NO_BRACE);
            end
         end
         P_N_REST: r = id_char(c) ? take_to(r, p) : finish(r);
         P_G_REST: r = (id_char(c) || eq(c, "-")) ? take_to(r, p) : finish(r);
         P_A_USER:
            r = (id_char(c) || eq(c, "-")) ? take_to(r, p)
              : eq(c, ">") ? finish(take_to(r, P_IDLE)) : fail(r, ERR_BAD_CHAR);
         P_I_FIRST: r = is_digit(c) ? take_to(r, P_I_DIG) : fail(r, ERR_BAD_CHAR);
         P_I_DIG:
            r = is_digit(c) ? take_to(r, p)
              : eq(c, "K") ? finish(take_to(r, P_IDLE)) : finish(r);
         P_WORD_T, P_WORD_F: begin
            if (word_hit(p == P_WORD_F, s.pos, c)) begin
               r = take_to(r, p);
               r.st.pos = s.pos + 4'd1;
               if (r.st.pos >= ((p == P_WORD_F) ? 4'd5 : 4'd4)) r = finish(r);
            end else begin
               r = fail(r, ERR_BAD_CHAR);
            end
         end
         P_O1:
            r = eq(c, "n") ? finish(take_to(r, P_IDLE))
              : eq(c, "f") ? take_to(r, P_O2) : fail(r, ERR_BAD_CHAR);
         P_O2: r = eq(c, "f") ? finish(take_to(r, P_IDLE)) : fail(r, ERR_BAD_CHAR);
         P_FL_INT, P_FL_FRAC: begin
            if (is_digit(c)) r = take_to(r, p);
            else if (p == P_FL_INT && eq(c, ".")) r = take_to(r, P_FL_FRAC);
            else if (eq(c, "e") || eq(c, "E")) r = take_to(r, P_FL_EXP0);
            else r = finish(r);
         end
         P_FL_EXP0:
            r = (is_digit(c) || eq(c, "+") || eq(c, "-")) ? take_to(r, P_FL_EXPD)
                                                          : fail(r, ERR_BAD_CHAR);
         P_FL_EXPD: r = is_digit(c) ? take_to(r, p) : finish(r);
         default: r.st.phase = P_IDLE;
      endcase
      return r;
   endfunction

   function automatic logic probe(logic [4:0] k, logic [8:0] c, logic [8:0] l);
      logic m;
      if (k >= 5'd1 && k <= 5'd8) return c == single_ch(k);
      case (k)
         K_EOF: m = c == END_CH;
         K_ARROW: m = eq(c, "-") && eq(l, ">");
         K_WS: m = is_ws(c);
         K_COMMENT: m = eq(c, "/") && (eq(l, "/") || eq(l, "*"));
         K_PERM, K_SRV_OPT, K_CLI_OPT: m = eq(c, "[");
         K_ARG, K_PATH, K_FNAME: begin
            if (k != K_FNAME && eq(c, "/")) m = !eq(l, "/") && !eq(l, "*");
            else m = name_char(c) || eq(c, "'") || eq(c, "\"");
         end
         K_NAME, K_GROUP: m = id_start(c);
         K_AGENT: m = eq(c, "<") || id_start(c);
         K_INT: m = is_digit(c);
         K_SINT: m = eq(c, "+") || eq(c, "-") || is_digit(c);
         default: m = 1'b0;
      endcase
      return m;
   endfunction

   step_type      first_step;
   step_type      second_step;
   lex_state_type begin_state;

   always_comb begin
      begin_state = '{kind: token_kind, phase: P_START, quote_dbl: 1'b0,
                      brace_open: 1'b0, cand: 3'b111, pos: 4'd0};
      first_step  = lex_step((opcode == OP_BEGIN) ? begin_state : state_cur, cur, la);
      second_step = lex_step(first_step.st, cur, la);
      if (first_step.again) begin
         second_step.cons = second_step.cons | first_step.cons;
      end else begin
         second_step = first_step;
      end
      state_nxt = state_cur;
      flags = '{consumed: 1'b0, token_done: 1'b0, could_match: 1'b0,
                error_code: ERR_NONE};
      case (opcode)
         OP_PROBE: begin
            if (token_kind >= K_BOOL) flags.error_code = ERR_NO_PROBE;
            else flags.could_match = probe(token_kind, cur, la);
         end
         OP_BEGIN: begin
            if (token_kind > K_STRING) begin
               state_nxt = begin_state;
               state_nxt.phase = P_IDLE;
               flags.token_done = 1'b1;
            end else begin
               state_nxt = second_step.st;
               flags.consumed = second_step.cons;
               flags.token_done = second_step.done;
               flags.error_code = second_step.err;
            end
         end
         OP_CONTINUE: begin
            if (state_cur.phase != P_IDLE) begin
               state_nxt = second_step.st;
               flags.consumed = second_step.cons;
               flags.token_done = second_step.done;
               flags.error_code = second_step.err;
            end
         end
         default: state_nxt = state_cur;
      endcase
   end

endmodule
`default_nettype wire

FILE: hw/rtl/predictive_token_lexer.sv
// Top level of the predictive token lexer: input register, lexer step, result register.
// Depends on ptl_pkg, ptl_if and ptl_core.
//
//  channel | direction | transaction
//  req     | in        | opcode, kind, current byte and lookahead with end flags
//  rsp     | out       | consumed, done, match, error, line and column
//
// One transaction a cycle unless rsp stalls; a request reaches rsp via both registers.
// The token state and counters update as a request leaves the input register.
// Reset clears the token state, sets line 1 column 0 and empties both registers.
// A stalled rsp holds its transaction while the input register still takes one more.
`default_nettype none
module predictive_token_lexer
   import ptl_pkg::*;
#(
   parameter int LINE_BITS   = 20,
   parameter int COLUMN_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   ptl_req_if.sink   req,
   ptl_rsp_if.source rsp
);

   logic                   in_valid_ff;
   logic [1:0]             in_op_ff;
   logic [4:0]             in_kind_ff;
   logic [8:0]             in_cur_ff;
   logic [8:0]             in_la_ff;
   lex_state_type          state_ff;
   lex_state_type          state_in;
   lex_flags_type          flags;
   logic [LINE_BITS-1:0]   line_ff;
   logic [LINE_BITS-1:0]   line_in;
   logic [COLUMN_BITS-1:0] col_ff;
   logic [COLUMN_BITS-1:0] col_in;
   logic                   out_valid_ff;
   lex_flags_type          out_flags_ff;
   logic                   advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   ptl_core u_core (
      .opcode     (in_op_ff),
      .token_kind (in_kind_ff),
      .cur        (in_cur_ff),
      .la         (in_la_ff),
      .state_cur  (state_ff),
      .state_nxt  (state_in),
      .flags      (flags)
   );

   always_comb begin
      line_in = line_ff;
      col_in  = col_ff;
      if (flags.consumed) begin
         if (in_cur_ff == 9'h00A) begin
            if (line_ff != {LINE_BITS{1'b1}}) line_in = line_ff + 1'b1;
            col_in = '0;
         end else if (col_ff != {COLUMN_BITS{1'b1}}) begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_op_ff   <= req.opcode;
         in_kind_ff <= req.token_kind;
         in_cur_ff  <= req.current_is_end ? END_CH : {1'b0, req.current_char};
         in_la_ff   <= req.lookahead_is_end ? END_CH : {1'b0, req.lookahead_char};
      end
      if (advance) out_flags_ff <= flags;
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{kind: 5'd0, phase: P_IDLE, quote_dbl: 1'b0,
                           brace_open: 1'b0, cand: 3'b111, pos: 4'd0};
         line_ff      <= {{(LINE_BITS-1){1'b0}}, 1'b1};
         col_ff       <= '0;
      end else begin
         if (req.ready) in_valid_ff <= req.valid;
         if (advance) begin
            state_ff     <= state_in;
            line_ff      <= line_in;
            col_ff       <= col_in;
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.consumed      = out_flags_ff.consumed;
   assign rsp.token_done    = out_flags_ff.token_done;
   assign rsp.could_match   = out_flags_ff.could_match;
   assign rsp.error_code    = out_flags_ff.error_code;
   assign rsp.line_number   = line_ff;
   assign rsp.column_number = col_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/ptl_checker.sv
// Port-level checks of the token lexer and their binding to the top level.
// Depends on predictive_token_lexer's port names.
`default_nettype none
module ptl_props #(
   parameter int LINE_BITS = 20
) (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic                 consumed,
   input wire logic                 token_done,
   input wire logic                 could_match,
   input wire logic [3:0]           error_code,
   input wire logic [LINE_BITS-1:0] line_number
);

   hold_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp transaction dropped while stalled");

   done_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && token_done |-> error_code == 4'd0)
      else $error("token done together with an error");

   probe_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && could_match |-> !consumed && !token_done)
      else $error("probe answer with byte taken");

   line_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> line_number != '0)
      else $error("line number zero");

   reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind predictive_token_lexer ptl_props #(.LINE_BITS(LINE_BITS)) u_ptl_props (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .consumed    (rsp.consumed),
   .token_done  (rsp.token_done),
   .could_match (rsp.could_match),
   .error_code  (rsp.error_code),
   .line_number (rsp.line_number)
);
`default_nettype wire

FILE: tb/sv/ptl_checker.sv
// Checker of the token lexer: watches both channels, predicts each response
// from the request stream and compares field by field. Depends on ptl_pkg and ptl_if.
`timescale 1ns / 100ps
`default_nettype none
module ptl_checker
   import ptl_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   ptl_req_if        req,
   ptl_rsp_if        rsp,
   output int        fail_count,
   output int        pending
);

   localparam int END_MARK = 256;

   typedef struct {
      bit         consumed;
      bit         token_done;
      bit         could_match;
      error_type  error_code;
      logic [19:0] line_number;
      logic [15:0] column_number;
   } lex_result_type;

   lex_result_type result_q[$];

   string option_words[3] = '{"[manual-start]", "[async]", "[types-only]"};
   int    option_lens[3]  = '{14, 7, 12};
   string punct_chars     = "{}():=.*";

   logic [4:0]  tok_kind;
   phase_type   phase;
   bit          quote_dbl, brace_seen, rerun;
   logic [2:0]  cand;
   logic [3:0]  pos;
   logic [19:0] line_cnt;
   logic [15:0] col_cnt;
   bit          f_cons, f_done, f_match;
   error_type   f_err;

   function automatic bit is_lower(int c); return c >= "a" && c <= "z"; endfunction
   function automatic bit is_digit(int c); return c >= "0" && c <= "9"; endfunction
   function automatic bit id_start(int c);
      return is_lower(c) || (c >= "A" && c <= "Z") || c == "_";
   endfunction
   function automatic bit id_char(int c); return id_start(c) || is_digit(c); endfunction
   function automatic bit is_ws(int c);
      return c == " " || c == 9 || c == 10 || c == 13;
   endfunction
   function automatic bit name_char(int c);
      return id_char(c) || c == "." || c == "$" || c == "-" || c == ":" || c == ";" ||
             c == "+" || c == "=" || c == "?";
   endfunction
   function automatic bit path_char(int c); return name_char(c) || c == "/"; endfunction

   function automatic int punct_of(logic [4:0] k);
      return punct_chars[k - 1];
   endfunction

   function automatic void take_byte(int c);
      f_cons = 1;
      if (c == 10) begin
         if (line_cnt != '1) line_cnt++;
         col_cnt = '0;
      end else if (col_cnt != '1) begin
         col_cnt++;
      end
   endfunction

   function automatic void close_token();
      f_done = 1;
      phase = P_IDLE;
   endfunction

   function automatic void abort_token(error_type e);
      f_err = e;
      phase = P_IDLE;
   endfunction

   function automatic bit could_start(logic [4:0] k, int c, int la);
      if (k >= 5'd1 && k <= 5'd8) return c == punct_of(k);
      case (k)
         K_EOF:     return c == END_MARK;
         K_ARROW:   return c == "-" && la == ">";
         K_WS:      return is_ws(c);
         K_COMMENT: return c == "/" && (la == "/" || la == "*");
         K_PERM, K_SRV_OPT, K_CLI_OPT: return c == "[";
         K_ARG, K_PATH, K_FNAME: begin
            if (k != K_FNAME && c == "/") return la != "/" && la != "*";
            return name_char(c) || c == "'" || c == "\"";
         end
         K_NAME, K_GROUP: return id_start(c);
         K_AGENT:   return c == "<" || id_start(c);
         K_INT:     return is_digit(c);
         K_SINT:    return c == "+" || c == "-" || is_digit(c);
         default:   return 0;
      endcase
   endfunction

   function automatic void unquoted_step(int c, int la, bit first);
      bit pathy, cls, cmt;
      pathy = tok_kind != K_FNAME;
      cls = pathy ? path_char(c) : name_char(c);
      cmt = pathy && c == "/" && (la == "/" || la == "*");
      if (c == "$") begin
         take_byte(c);
         phase = P_E_DOLLAR;
      end else if (cls && !cmt) begin
         take_byte(c);
         phase = P_U_MORE;
      end else if (first) begin
         abort_token(ERR_BAD_CHAR);
      end else begin
         close_token();
      end
   endfunction

   function automatic bit option_complete();
      logic [2:0] mask;
      mask = (tok_kind == K_SRV_OPT) ? 3'b011 : 3'b101;
      for (int i = 0; i < 3; i++)
         if (mask[i] && cand[i] && int'(pos) == option_lens[i] - 2) return 1;
      return 0;
   endfunction

   function automatic void bracket_step(int c);
      bit opt;
      opt = tok_kind != K_PERM;
      if (c == END_MARK) begin
         abort_token(ERR_EARLY_END);
         return;
      end
      if (opt ? !(c == "-" || is_lower(c)) : !(c == "r" || c == "w" || c == "x")) begin
         abort_token(ERR_BAD_CHAR);
         return;
      end
      take_byte(c);
      if (opt) begin
         for (int i = 0; i < 3; i++)
            if (!(int'(pos) < option_lens[i] - 2 && int'(option_words[i][pos + 1]) == c))
               cand[i] = 0;
         if (pos < 4'd15) pos++;
      end
      phase = P_BR_MORE;
   endfunction

   function automatic void word_step(int c, string w);
      if (int'(pos) < w.len() && c == int'(w[pos])) begin
         take_byte(c);
         pos++;
         if (int'(pos) >= w.len()) close_token();
      end else begin
         abort_token(ERR_BAD_CHAR);
      end
   endfunction

   function automatic void start_step(int c, int la);
      logic [4:0] k;
      k = tok_kind;
      if (k >= 5'd1 && k <= 5'd8) begin
         if (c == punct_of(k)) begin
            take_byte(c);
            close_token();
         end else abort_token(ERR_BAD_CHAR);
         return;
      end
      case (k)
         K_EOF: if (c == END_MARK) close_token(); else abort_token(ERR_BAD_CHAR);
         K_ARROW: if (c == "-") begin
            take_byte(c);
            phase = P_ARROW2;
         end else abort_token(ERR_BAD_CHAR);
         K_WS: if (is_ws(c)) begin
            take_byte(c);
            phase = P_WS_MORE;
         end else abort_token(ERR_EMPTY_TOKEN);
         K_COMMENT: if (c == "/") begin
            take_byte(c);
            phase = P_CM_SLASH;
         end else abort_token(ERR_BAD_CHAR);
         K_PERM, K_SRV_OPT, K_CLI_OPT: if (c == "[") begin
            take_byte(c);
            phase = P_BR_FIRST;
         end else abort_token(ERR_BAD_CHAR);
         K_ARG, K_PATH, K_FNAME, K_STRING: begin
            if (c == "\"" || c == "'") begin
               quote_dbl = c == "\"";
               take_byte(c);
               phase = P_QUOTE;
            end else if (k == K_STRING) abort_token(ERR_BAD_CHAR);
            else unquoted_step(c, la, 1);
         end
         K_NAME, K_GROUP: if (id_start(c)) begin
            take_byte(c);
            phase = (k == K_NAME) ? P_N_REST : P_G_REST;
         end else abort_token(ERR_BAD_CHAR);
         K_AGENT: begin
            if (c == "<") begin
               take_byte(c);
               phase = P_A_USER;
            end else if (id_start(c)) begin
               take_byte(c);
               phase = P_N_REST;
            end else abort_token(ERR_BAD_CHAR);
         end
         K_INT: begin
            phase = P_I_FIRST;
            rerun = 1;
         end
         K_SINT: begin
            phase = P_I_FIRST;
            if (c == "+" || c == "-") take_byte(c); else rerun = 1;
         end
         K_BOOL: begin
            if (c == "t") begin
               take_byte(c);
               pos = 1;
               phase = P_WORD_T;
            end else if (c == "f") begin
               take_byte(c);
               pos = 1;
               phase = P_WORD_F;
            end else if (c == "o") begin
               take_byte(c);
               phase = P_O1;
            end else abort_token(ERR_BAD_CHAR);
         end
         K_FLOAT: if (is_digit(c) || c == "+" || c == "-") begin
            take_byte(c);
            phase = P_FL_INT;
         end else abort_token(ERR_BAD_CHAR);
         default: close_token();
      endcase
   endfunction

   function automatic void lex_byte(int c, int la);
      rerun = 1;
      while (rerun) begin
         rerun = 0;
         case (phase)
            P_START: start_step(c, la);
            P_ARROW2: if (c == ">") begin
               take_byte(c);
               close_token();
            end else abort_token(ERR_BAD_CHAR);
            P_WS_MORE: if (is_ws(c)) take_byte(c); else close_token();
            P_CM_SLASH: begin
               if (c == "/") begin
                  take_byte(c);
                  phase = P_CM_LINE;
               end else if (c == "*") begin
                  take_byte(c);
                  phase = P_CM_BLOCK;
               end else abort_token(ERR_BAD_CHAR);
            end
            P_CM_LINE: if (c == 10 || c == END_MARK) close_token(); else take_byte(c);
            P_CM_BLOCK, P_CM_STAR: begin
               if (phase == P_CM_STAR && c == "/") begin
                  take_byte(c);
                  close_token();
               end else if (c == "*") begin
                  take_byte(c);
                  phase = P_CM_STAR;
               end else if (c == END_MARK) abort_token(ERR_EARLY_END);
               else begin
                  take_byte(c);
                  phase = P_CM_BLOCK;
               end
            end
            P_BR_FIRST: if (c == "]") abort_token(ERR_EMPTY_BR); else bracket_step(c);
            P_BR_MORE: begin
               if (c == "]") begin
                  take_byte(c);
                  if (tok_kind != K_PERM && !option_complete()) abort_token(ERR_BAD_OPTION);
                  else close_token();
               end else bracket_step(c);
            end
            P_QUOTE: begin
               if (c == (quote_dbl ? "\"" : "'")) begin
                  take_byte(c);
                  close_token();
               end else if (c == END_MARK) abort_token(ERR_EARLY_END);
               else if (c == 10 || c == 13) abort_token(ERR_NL_QUOTE);
               else take_byte(c);
            end
            P_U_MORE: unquoted_step(c, la, 0);
            P_E_DOLLAR: begin
               phase = P_E_FIRST;
               if (c == "{") begin
                  take_byte(c);
                  brace_seen = 1;
               end else begin
                  brace_seen = 0;
                  rerun = 1;
               end
            end
            P_E_FIRST: if (id_start(c)) begin
               take_byte(c);
               phase = P_E_REST;
            end else abort_token(ERR_BAD_CHAR);
            P_E_REST: begin
               if (id_char(c)) take_byte(c);
               else if (!brace_seen) begin
                  phase = P_U_MORE;
                  rerun = 1;
               end else if (c == "}") begin
                  take_byte(c);
                  brace_seen = 0;
                  phase = P_U_MORE;
               end else if (c == END_MARK) abort_token(ERR_EARLY_END);
               else abort_token(ERR_NO_BRACE);
            end
            P_N_REST: if (id_char(c)) take_byte(c); else close_token();
            P_G_REST: if (id_char(c) || c == "-") take_byte(c); else close_token();
            P_A_USER: begin
               if (id_char(c) || c == "-") take_byte(c);
               else if (c == ">") begin
                  take_byte(c);
                  close_token();
               end else abort_token(ERR_BAD_CHAR);
            end
            P_I_FIRST: if (is_digit(c)) begin
               take_byte(c);
               phase = P_I_DIG;
            end else abort_token(ERR_BAD_CHAR);
            P_I_DIG: begin
               if (is_digit(c)) take_byte(c);
               else begin
                  if (c == "K") take_byte(c);
                  close_token();
               end
            end
            P_WORD_T: word_step(c, "true");
            P_WORD_F: word_step(c, "false");
            P_O1: begin
               if (c == "n") begin
                  take_byte(c);
                  close_token();
               end else if (c == "f") begin
                  take_byte(c);
                  phase = P_O2;
               end else abort_token(ERR_BAD_CHAR);
            end
            P_O2: if (c == "f") begin
               take_byte(c);
               close_token();
            end else abort_token(ERR_BAD_CHAR);
            P_FL_INT, P_FL_FRAC: begin
               if (is_digit(c)) take_byte(c);
               else if (phase == P_FL_INT && c == ".") begin
                  take_byte(c);
                  phase = P_FL_FRAC;
               end else if (c == "e" || c == "E") begin
                  take_byte(c);
                  phase = P_FL_EXP0;
               end else close_token();
            end
            P_FL_EXP0: if (is_digit(c) || c == "+" || c == "-") begin
               take_byte(c);
               phase = P_FL_EXPD;
            end else abort_token(ERR_BAD_CHAR);
            P_FL_EXPD: if (is_digit(c)) take_byte(c); else close_token();
            default: phase = P_IDLE;
         endcase
      end
   endfunction

   function automatic lex_result_type predict_lexeme(opcode_type op, logic [4:0] k,
                                                     int c, int la);
      lex_result_type r;
      f_cons = 0; f_done = 0; f_match = 0; f_err = ERR_NONE;
      if (op == OP_PROBE) begin
         if (k >= K_BOOL) f_err = ERR_NO_PROBE;
         else f_match = could_start(k, c, la);
      end else if (op == OP_BEGIN) begin
         tok_kind = k;
         quote_dbl = 0; brace_seen = 0; cand = '1; pos = '0;
         if (k > K_STRING) begin
            phase = P_IDLE;
            f_done = 1;
         end else begin
            phase = P_START;
            lex_byte(c, la);
         end
      end else if (op == OP_CONTINUE && phase != P_IDLE) begin
         lex_byte(c, la);
      end
      r.consumed = f_cons; r.token_done = f_done; r.could_match = f_match;
      r.error_code = f_err; r.line_number = line_cnt; r.column_number = col_cnt;
      return r;
   endfunction

   initial begin
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      lex_result_type r;
      int c, la;
      if (reset) begin
         tok_kind = '0; phase = P_IDLE; quote_dbl = 0; brace_seen = 0;
         cand = '1; pos = '0; line_cnt = 20'd1; col_cnt = '0;
         result_q.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (result_q.size() == 0) begin
               $error("unexpected response transaction");
               fail_count++;
            end else begin
               r = result_q.pop_front();
               if (rsp.consumed !== r.consumed) begin
                  $error("consumed: expected %0d, got %0d", r.consumed, rsp.consumed);
                  fail_count++;
               end
               if (rsp.token_done !== r.token_done) begin
                  $error("token_done: expected %0d, got %0d", r.token_done, rsp.token_done);
                  fail_count++;
               end
               if (rsp.could_match !== r.could_match) begin
                  $error("could_match: expected %0d, got %0d", r.could_match,
                         rsp.could_match);
                  fail_count++;
               end
               if (rsp.error_code !== r.error_code) begin
                  $error("error_code: expected %0d, got %0d", r.error_code, rsp.error_code);
                  fail_count++;
               end
               if (rsp.line_number !== r.line_number) begin
                  $error("line_number: expected %0d, got %0d", r.line_number,
                         rsp.line_number);
                  fail_count++;
               end
               if (rsp.column_number !== r.column_number) begin
                  $error("column_number: expected %0d, got %0d", r.column_number,
                         rsp.column_number);
                  fail_count++;
               end
            end
         end
         if (req.valid && req.ready) begin
            c  = req.current_is_end ? END_MARK : int'(req.current_char);
            la = req.lookahead_is_end ? END_MARK : int'(req.lookahead_char);
            result_q.push_back(predict_lexeme(opcode_type'(req.opcode), req.token_kind, c, la));
         end
      end
      pending <= result_q.size();
   end

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
// Top of the token lexer testbench: clock, reset, request stimulus and response stalls.
// Depends on ptl_pkg, ptl_if, predictive_token_lexer and ptl_checker.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   import ptl_pkg::*;

   localparam int END_MARK = 256;
   localparam int ITEM_TARGET = 1000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending;
   int   sent = 0;
   bit   sender_busy = 0;
   bit   sink_busy = 0;
   int   stall = 0;
   int   lexeme[$];

   ptl_req_if req_ch (clock);
   ptl_rsp_if rsp_ch (clock);

   predictive_token_lexer u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   ptl_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #5 clock = ~clock;

   initial begin
      #5ms;
      $display("Simulation FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall <= 0;
      end else if (stall != 0) begin
         stall <= stall - 1;
         rsp_ch.ready <= (stall == 1);
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         int n;
         n = sink_busy ? $urandom_range(0, 17) : 0;
         stall <= n;
         rsp_ch.ready <= (n == 0);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   task automatic send_lexeme_byte(opcode_type op, logic [4:0] k, int c, int la);
      int gap;
      gap = sender_busy ? $urandom_range(0, 17) : 0;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid            <= 1'b1;
      req_ch.opcode           <= op;
      req_ch.token_kind       <= k;
      req_ch.current_is_end   <= (c == END_MARK);
      req_ch.current_char     <= (c == END_MARK) ? 8'($urandom) : 8'(c);
      req_ch.lookahead_is_end <= (la == END_MARK);
      req_ch.lookahead_char   <= (la == END_MARK) ? 8'($urandom) : 8'(la);
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent++;
   endtask

   function automatic int pick(string s);
      return s[$urandom_range(0, s.len() - 1)];
   endfunction

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++) lexeme.push_back(s[i]);
   endfunction

   function automatic void push_run(string s, int lo, int hi);
      repeat ($urandom_range(lo, hi)) lexeme.push_back(pick(s));
   endfunction

   function automatic void build_lexeme(logic [4:0] k);
      string opts[3] = '{"[manual-start]", "[async]", "[types-only]"};
      string bools[5] = '{"true", "false", "on", "off", "o"};
      string ids = "abcXYZ_09";
      lexeme.delete();
      if (k >= 5'd1 && k <= 5'd8) begin
         push_text(string'("{}():=.*"));
         lexeme = '{lexeme[k - 1]};
         return;
      end
      case (k)
         K_ARROW: push_text("->");
         K_WS: push_run(" \t\n\r", 1, 5);
         K_COMMENT: begin
            if ($urandom_range(0, 1)) begin
               push_text("//");
               push_run("ab */", 0, 6);
            end else begin
               push_text("/*");
               push_run("a*\n/", 0, 6);
               push_text("*/");
            end
         end
         K_PERM: begin
            push_text("[");
            push_run("rwx", 1, 3);
            push_text("]");
         end
         K_SRV_OPT, K_CLI_OPT: begin
            if ($urandom_range(0, 3) != 0) push_text(opts[$urandom_range(0, 2)]);
            else begin
               push_text("[");
               push_run("-amnstyp", 0, 5);
               push_text("]");
            end
         end
         K_ARG, K_PATH, K_FNAME: begin
            case ($urandom_range(0, 4))
               0: push_run("abz/._-:;+=?", 1, 6);
               1: begin
                  push_text("$");
                  push_run("AZ_a", 1, 4);
                  push_run("/.b", 0, 3);
               end
               2: begin
                  push_text("a${");
                  push_run("HOME_1", 1, 4);
                  push_text($urandom_range(0, 3) ? "}/x" : "#");
               end
               3: begin
                  push_text("'");
                  push_run("q s\"", 0, 4);
                  push_text("'");
               end
               default: begin
                  push_text("\"");
                  push_run("a b'/", 0, 4);
                  push_text("\"");
               end
            endcase
         end
         K_NAME, K_GROUP: begin
            lexeme.push_back(pick("abQ_"));
            push_run(k == K_GROUP ? "a1Z_-" : "a1Z_", 0, 6);
         end
         K_AGENT: begin
            if ($urandom_range(0, 1)) begin
               push_text("<");
               push_run(ids, 1, 5);
               push_text(">");
            end else push_run("abQ_", 1, 5);
         end
         K_INT, K_SINT: begin
            if (k == K_SINT && $urandom_range(0, 1)) lexeme.push_back(pick("+-"));
            push_run("0123456789", 1, 6);
            if ($urandom_range(0, 3) == 0) push_text("K");
         end
         K_BOOL: push_text(bools[$urandom_range(0, 4)]);
         K_FLOAT: begin
            push_run("+-0123456789", 1, 4);
            if ($urandom_range(0, 1)) begin
               push_text(".");
               push_run("0123456789", 0, 3);
            end
            if ($urandom_range(0, 1)) begin
               lexeme.push_back(pick("eE"));
               push_run("+-012345", 1, 3);
            end
         end
         K_STRING: begin
            lexeme.push_back(pick("\"'"));
            push_run("ab 9\"'", 0, 6);
            if ($urandom_range(0, 5) == 0) push_text("\n");
            lexeme.push_back(pick("\"'"));
         end
         default: ;
      endcase
   endfunction

   task automatic run_lexeme(logic [4:0] k);
      int term, la;
      build_lexeme(k);
      if ($urandom_range(0, 7) == 0 && lexeme.size() != 0)
         lexeme[$urandom_range(0, lexeme.size() - 1)] = $urandom_range(0, 255);
      term = $urandom_range(0, 5) == 0 ? END_MARK : pick(" \n;)=/");
      if ($urandom_range(0, 3) == 0)
         send_lexeme_byte(OP_PROBE, k, lexeme.size() ? lexeme[0] : term,
                          lexeme.size() > 1 ? lexeme[1] : term);
      if (lexeme.size() == 0) begin
         send_lexeme_byte(OP_BEGIN, k, (k == K_EOF) ? END_MARK : term, $urandom_range(0, 255));
         return;
      end
      for (int i = 0; i < lexeme.size(); i++) begin
         la = (i + 1 < lexeme.size()) ? lexeme[i + 1] : term;
         send_lexeme_byte(i == 0 ? OP_BEGIN : OP_CONTINUE, k, lexeme[i], la);
      end
      send_lexeme_byte(OP_CONTINUE, k, term,
                       term == END_MARK ? END_MARK : $urandom_range(0, 256));
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.opcode = OP_PROBE;
      req_ch.token_kind = '0;
      req_ch.current_char = '0;
      req_ch.current_is_end = 1'b0;
      req_ch.lookahead_char = '0;
      req_ch.lookahead_is_end = 1'b0;
      rsp_ch.ready = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_lexeme_byte(OP_PROBE, K_BOOL, "t", "r");
      send_lexeme_byte(OP_PROBE, 5'd31, 8'hFF, 8'h00);
      send_lexeme_byte(OP_PROBE, K_EOF, END_MARK, END_MARK);
      send_lexeme_byte(OP_BEGIN, 5'd26, "x", "y");
      send_lexeme_byte(OP_CONTINUE, K_NAME, "a", "b");
      send_lexeme_byte(OP_NONE, 5'd31, 8'hFF, 8'hFF);
      send_lexeme_byte(OP_BEGIN, K_BOOL, "o", "x");
      send_lexeme_byte(OP_CONTINUE, K_BOOL, "x", " ");
      send_lexeme_byte(OP_BEGIN, K_COMMENT, "/", "*");
      send_lexeme_byte(OP_CONTINUE, K_COMMENT, "*", END_MARK);
      send_lexeme_byte(OP_CONTINUE, K_COMMENT, END_MARK, END_MARK);
      send_lexeme_byte(OP_BEGIN, K_STRING, "\"", 10);
      send_lexeme_byte(OP_CONTINUE, K_STRING, 10, "a");
      send_lexeme_byte(OP_BEGIN, K_PERM, "[", "]");
      send_lexeme_byte(OP_CONTINUE, K_PERM, "]", " ");
      send_lexeme_byte(OP_BEGIN, K_WS, "x", " ");
      send_lexeme_byte(OP_BEGIN, K_ARG, "$", "{");
      send_lexeme_byte(OP_CONTINUE, K_ARG, "{", "A");
      send_lexeme_byte(OP_CONTINUE, K_ARG, "A", "#");
      send_lexeme_byte(OP_CONTINUE, K_ARG, "#", " ");
      send_lexeme_byte(OP_BEGIN, K_NAME, "a", "5");
      send_lexeme_byte(OP_BEGIN, K_INT, "5", " ");
      send_lexeme_byte(OP_CONTINUE, K_INT, 8'h00, " ");
      drain_results();

      while (sent < ITEM_TARGET) begin
         if ($urandom_range(0, 40) == 0) begin
            sender_busy = $urandom_range(0, 2) != 0;
            sink_busy = $urandom_range(0, 2) != 0;
         end
         if ($urandom_range(0, 6) == 0)
            send_lexeme_byte(opcode_type'($urandom_range(0, 3)), 5'($urandom),
                             $urandom_range(0, 256), $urandom_range(0, 256));
         else
            run_lexeme(5'($urandom_range(0, 27)));
         if ($urandom_range(0, 150) == 0) drain_results();
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (fail_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
`default_nettype wire

FILE: sim.f
hw/rtl/ptl_pkg.sv
hw/rtl/ptl_if.sv
hw/rtl/ptl_core.sv
hw/rtl/predictive_token_lexer.sv
hw/rtl/ptl_checker.sv
tb/sv/ptl_checker.sv
tb/sv/tb_top.sv
